// ===== hdl/svfpn_pkg.sv =====
`timescale 1ns / 1ps

package svfpn_pkg;

   // Register indexes on the configuration port (byte address is 4 * index).
   localparam logic [2:0] REG_CUTOFF_BASE      = 3'd0;
   localparam logic [2:0] REG_CUTOFF_OFFSET    = 3'd1;
   localparam logic [2:0] REG_RESONANCE_BASE   = 3'd2;
   localparam logic [2:0] REG_RESONANCE_OFFSET = 3'd3;
   localparam logic [2:0] REG_RESPONSE_MODE    = 3'd4;
   localparam logic [2:0] REG_WINDOW_LENGTH    = 3'd5;
   localparam logic [2:0] REG_BOOST_NUMERATOR  = 3'd6;

   // Response selection codes.
   localparam logic [1:0] MODE_LOWPASS  = 2'd0;
   localparam logic [1:0] MODE_HIGHPASS = 2'd1;
   localparam logic [1:0] MODE_BANDPASS = 2'd2;
   localparam logic [1:0] MODE_NOTCH    = 2'd3;

   // Fixed constants of the normalizer and coefficient clamps.
   localparam int NORM_TARGET  = 16000;
   localparam int GAIN_UNITY   = 256;
   localparam int GAIN_MAX     = 1024;
   localparam int CUT_MIN      = 20;
   localparam int CUT_MAX      = 230;
   localparam int RES_MAX      = 220;
   localparam int WINDOW_RESET = 2400;
   localparam int DIV_DIVIDEND = NORM_TARGET * GAIN_UNITY;
   // At or below this peak the quotient reaches the gain cap.
   localparam int GAIN_KNEE    = DIV_DIVIDEND / GAIN_MAX;

   typedef struct packed {
      logic signed [15:0] sample_in;
      logic signed [7:0]  cutoff_mod;
      logic               start_req;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic [10:0]        gain_now;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        cutoff_base;
      logic signed [8:0] cutoff_offset;
      logic [7:0]        resonance_base;
      logic signed [7:0] resonance_offset;
      logic [1:0]        response_mode;
      logic [15:0]       window_length;
      logic [2:0]        boost_numerator;
   } cfg_type;

endpackage

// ===== hdl/svfpn_csr.sv =====
`timescale 1ns / 1ps

module svfpn_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output svfpn_pkg::cfg_type cfg
);
   import svfpn_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; writes beyond the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_CUTOFF_BASE:      cfg_in.cutoff_base      = pwdata[7:0];
            REG_CUTOFF_OFFSET:    cfg_in.cutoff_offset    = $signed(pwdata[8:0]);
            REG_RESONANCE_BASE:   cfg_in.resonance_base   = pwdata[7:0];
            REG_RESONANCE_OFFSET: cfg_in.resonance_offset = $signed(pwdata[7:0]);
            REG_RESPONSE_MODE:    cfg_in.response_mode    = pwdata[1:0];
            REG_WINDOW_LENGTH:    cfg_in.window_length    = pwdata[15:0];
            REG_BOOST_NUMERATOR:  cfg_in.boost_numerator  = pwdata[2:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cutoff_base      <= 8'd200;
         cfg_ff.cutoff_offset    <= 9'sd0;
         cfg_ff.resonance_base   <= 8'd100;
         cfg_ff.resonance_offset <= 8'sd0;
         cfg_ff.response_mode    <= MODE_LOWPASS;
         cfg_ff.window_length    <= 16'(WINDOW_RESET);
         cfg_ff.boost_numerator  <= 3'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux.
   always_comb begin
      case (reg_index)
         REG_CUTOFF_BASE:      prdata = {24'd0, cfg_ff.cutoff_base};
         REG_CUTOFF_OFFSET:    prdata = {23'd0, cfg_ff.cutoff_offset};
         REG_RESONANCE_BASE:   prdata = {24'd0, cfg_ff.resonance_base};
         REG_RESONANCE_OFFSET: prdata = {24'd0, cfg_ff.resonance_offset};
         REG_RESPONSE_MODE:    prdata = {30'd0, cfg_ff.response_mode};
         REG_WINDOW_LENGTH:    prdata = {16'd0, cfg_ff.window_length};
         REG_BOOST_NUMERATOR:  prdata = {29'd0, cfg_ff.boost_numerator};
         default:              prdata = 32'd0;
      endcase
   end

endmodule

// ===== hdl/svfpn_mul.sv =====
`timescale 1ns / 1ps

module svfpn_mul (
   input  logic signed [31:0] mul_a,
   input  logic signed [11:0] mul_b,
   output logic signed [43:0] mul_p
);

   // Shared signed multiplier; the sequencer registers the product.
   assign mul_p = mul_a * mul_b;

endmodule

// ===== hdl/svfpn_div.sv =====
`timescale 1ns / 1ps

module svfpn_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        div_start,
   input  logic [15:0] divisor,
   output logic        div_done,
   output logic [9:0]  quotient
);
   import svfpn_pkg::*;

   logic        busy_ff,  busy_in;
   logic        done_ff,  done_in;
   logic [3:0]  cnt_ff,   cnt_in;
   logic [21:0] rem_ff,   rem_in;
   logic [24:0] dsh_ff,   dsh_in;
   logic [9:0]  quo_ff,   quo_in;
   logic [25:0] diff;

   assign diff     = {4'd0, rem_ff} - {1'b0, dsh_ff};
   assign div_done = done_ff;
   assign quotient = quo_ff;

   // Restoring division of the fixed dividend, one quotient bit per cycle.
   // The caller only starts it when the quotient is known to fit in ten bits.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd9;
         rem_in  = 22'(DIV_DIVIDEND);
         dsh_in  = {divisor, 9'd0};
         quo_in  = 10'd0;
      end else if (busy_ff) begin
         if (!diff[25]) begin
            rem_in = diff[21:0];
            quo_in = {quo_ff[8:0], 1'b1};
         end else begin
            quo_in = {quo_ff[8:0], 1'b0};
         end
         dsh_in = {1'b0, dsh_ff[24:1]};
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== hdl/svf_filter_peak_normalizer.sv =====
`timescale 1ns / 1ps

// Peak-normalized Chamberlin state-variable filter. Each transaction on the
// req_ channel carries one sample, a cutoff modulation and a start flag, and
// produces exactly one transaction on the rsp_ channel with the filtered,
// normalized and boosted sample plus the current 3.8 gain. One shared
// 32x12 multiplier is stepped by a small sequencer through the filter
// recursion and the output scaling; when a new peak above 4000 is seen
// inside the window, an iterative divider computes the new gain.
// req_stall stays high while a transaction is in flight. A finished result
// waits in the output register, and a new transaction may be accepted
// meanwhile.

module svf_filter_peak_normalizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  svfpn_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output svfpn_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import svfpn_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_M1   = 4'd1;
   localparam logic [3:0] ST_HP   = 4'd2;
   localparam logic [3:0] ST_M2   = 4'd3;
   localparam logic [3:0] ST_BP   = 4'd4;
   localparam logic [3:0] ST_M3   = 4'd5;
   localparam logic [3:0] ST_LP   = 4'd6;
   localparam logic [3:0] ST_Y    = 4'd7;
   localparam logic [3:0] ST_PK   = 4'd8;
   localparam logic [3:0] ST_DIV  = 4'd9;
   localparam logic [3:0] ST_M4   = 4'd10;
   localparam logic [3:0] ST_M5   = 4'd11;
   localparam logic [3:0] ST_OUT  = 4'd12;

   function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
      if (v > 44'sd32767) begin
         sat16 = 16'sh7FFF;
      end else if (v < -44'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

   cfg_type cfg;

   logic [3:0]         state_ff,  state_in;
   logic signed [15:0] x_ff,      x_in;
   logic [7:0]         f_ff,      f_in;
   logic [7:0]         q_ff,      q_in;
   logic signed [31:0] lp_ff,     lp_in;
   logic signed [31:0] bp_ff,     bp_in;
   logic signed [31:0] hp_ff,     hp_in;
   logic signed [43:0] prod_ff,   prod_in;
   logic signed [15:0] y_ff,      y_in;
   logic [15:0]        peak_ff,   peak_in;
   logic [10:0]        gain_ff,   gain_in;
   logic [15:0]        win_ff,    win_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;

   logic signed [31:0] mul_a;
   logic signed [11:0] mul_b;
   logic signed [43:0] mul_p;
   logic               div_start;
   logic               div_done;
   logic [9:0]         div_quo;

   logic signed [10:0] f_sum;
   logic signed [9:0]  q_sum;
   logic signed [32:0] y_sel;
   logic signed [16:0] y_ext;
   logic [16:0]        mag;
   logic [2:0]         numer;
   logic signed [43:0] half;
   logic               req_accept;
   logic               out_free;

   svfpn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   svfpn_mul u_mul (
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   svfpn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .divisor   (mag[15:0]),
      .div_done  (div_done),
      .quotient  (div_quo)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Coefficients for the accepted transaction.
   assign f_sum = $signed({3'd0, cfg.cutoff_base}) + 11'(cfg.cutoff_offset)
                + 11'(req_data.cutoff_mod);
   assign q_sum = $signed({2'd0, cfg.resonance_base}) + 10'(cfg.resonance_offset);

   // Response selection; the notch sum keeps its carry bit.
   always_comb begin
      case (cfg.response_mode)
         MODE_HIGHPASS: y_sel = 33'(hp_ff);
         MODE_BANDPASS: y_sel = 33'(bp_ff);
         MODE_NOTCH:    y_sel = 33'(hp_ff) + 33'(lp_ff);
         default:       y_sel = 33'(lp_ff);
      endcase
   end

   assign y_ext = 17'(y_ff);
   assign mag   = y_ff[15] ? 17'(-y_ext) : 17'(y_ext);

   // Boost numerator limited to the range two through six.
   always_comb begin
      if (cfg.boost_numerator < 3'd2) begin
         numer = 3'd2;
      end else if (cfg.boost_numerator > 3'd6) begin
         numer = 3'd6;
      end else begin
         numer = cfg.boost_numerator;
      end
   end

   // Halving rounds toward zero.
   assign half = $signed(prod_ff + {43'd0, prod_ff[43]}) >>> 1;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_M1: begin
            mul_a = bp_ff;
            mul_b = {4'd0, q_ff};
         end
         ST_M2: begin
            mul_a = hp_ff;
            mul_b = {4'd0, f_ff};
         end
         ST_M3: begin
            mul_a = bp_ff;
            mul_b = {4'd0, f_ff};
         end
         ST_M4: begin
            mul_a = 32'(y_ff);
            mul_b = {1'b0, gain_ff};
         end
         ST_M5: begin
            mul_a = prod_ff[39:8];
            mul_b = {9'd0, numer};
         end
         default: begin
            mul_a = bp_ff;
            mul_b = 12'sd0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      f_in         = f_ff;
      q_in         = q_ff;
      lp_in        = lp_ff;
      bp_in        = bp_ff;
      hp_in        = hp_ff;
      prod_in      = prod_ff;
      y_in         = y_ff;
      peak_in      = peak_ff;
      gain_in      = gain_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_in = req_data.sample_in;
               if (f_sum < 11'sd20) begin
                  f_in = 8'(CUT_MIN);
               end else if (f_sum > 11'sd230) begin
                  f_in = 8'(CUT_MAX);
               end else begin
                  f_in = f_sum[7:0];
               end
               if (q_sum < 10'sd0) begin
                  q_in = 8'd0;
               end else if (q_sum > 10'sd220) begin
                  q_in = 8'(RES_MAX);
               end else begin
                  q_in = q_sum[7:0];
               end
               // Start clears the filter and restarts the peak window.
               if (req_data.start_req) begin
                  lp_in   = 32'sd0;
                  bp_in   = 32'sd0;
                  peak_in = 16'd1;
                  gain_in = 11'(GAIN_UNITY);
                  win_in  = cfg.window_length;
               end
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            prod_in  = mul_p;
            state_in = ST_HP;
         end
         ST_HP: begin
            hp_in    = 32'(x_ff) - lp_ff - prod_ff[39:8];
            state_in = ST_M2;
         end
         ST_M2: begin
            prod_in  = mul_p;
            state_in = ST_BP;
         end
         ST_BP: begin
            bp_in    = bp_ff + prod_ff[39:8];
            state_in = ST_M3;
         end
         ST_M3: begin
            prod_in  = mul_p;
            state_in = ST_LP;
         end
         ST_LP: begin
            lp_in    = lp_ff + prod_ff[39:8];
            state_in = ST_Y;
         end
         ST_Y: begin
            y_in     = sat16(44'(y_sel));
            state_in = ST_PK;
         end
         ST_PK: begin
            state_in = ST_M4;
            if (win_ff != 16'd0) begin
               win_in = win_ff - 16'd1;
               if (mag > {1'b0, peak_ff}) begin
                  peak_in = mag[15:0];
                  if (mag <= 17'(GAIN_KNEE)) begin
                     gain_in = 11'(GAIN_MAX);
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               gain_in  = {1'b0, div_quo};
               state_in = ST_M4;
            end
         end
         ST_M4: begin
            prod_in  = mul_p;
            state_in = ST_M5;
         end
         ST_M5: begin
            prod_in  = mul_p;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.sample_out = sat16(half);
               rsp_data_in.gain_now   = gain_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lp_ff        <= 32'sd0;
         bp_ff        <= 32'sd0;
         peak_ff      <= 16'd1;
         gain_ff      <= 11'(GAIN_UNITY);
         win_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lp_ff        <= lp_in;
         bp_ff        <= bp_in;
         peak_ff      <= peak_in;
         gain_ff      <= gain_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      f_ff        <= f_in;
      q_ff        <= q_in;
      hp_ff       <= hp_in;
      prod_ff     <= prod_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted transaction always starts the recursion on the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_M1)
      else $error("accepted transaction did not start the sequencer");

   // A finished result waits while the previous one is still stalled.
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_OUT)
      else $error("result overwrote a stalled response");

   // The tracked peak never drops to zero.
   a_peak_nonzero: assert property (@(posedge clock) disable iff (reset)
      peak_ff != 16'd0)
      else $error("peak level reached zero");

   // A divider result is always below the gain cap.
   a_div_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done) |=> gain_ff < 11'(GAIN_MAX))
      else $error("divider gain out of range");

endmodule

// ===== test/svf_peak_norm_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register ports of the peak-normalized
// state-variable filter, predicts every result from its own copy of the
// filter state and register settings, and compares field by field.
module svf_peak_norm_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  svfpn_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  svfpn_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output int                  mismatch_count,
   output int                  pending_count
);

   import svfpn_pkg::*;

   // Register settings as seen by the predictor, widened to signed math.
   longint      cut_base;
   longint      cut_ofs;
   longint      res_base;
   longint      res_ofs;
   logic [1:0]  mode_sel;
   logic [15:0] win_len;
   logic [2:0]  boost_num;

   // Filter and normalizer state.
   longint      lp_acc;
   longint      bp_acc;
   longint      peak_mag;
   longint      gain_q88;
   logic [15:0] win_left;

   rsp_type     expected_samples[$];
   int          errors;

   function automatic longint limit(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // One step of the filter recursion plus normalization and boost.
   function automatic rsp_type filter_and_normalize(req_type item);
      longint  x;
      longint  f;
      longint  q;
      longint  hp;
      longint  bp;
      longint  lp;
      longint  y;
      longint  mag;
      longint  divisor;
      longint  scaled;
      longint  numer;
      rsp_type res;
      x = item.sample_in;
      if (item.start_req) begin
         lp_acc   = 0;
         bp_acc   = 0;
         peak_mag = 1;
         gain_q88 = GAIN_UNITY;
         win_left = win_len;
      end

      f = limit(cut_base + cut_ofs + longint'(item.cutoff_mod), CUT_MIN, CUT_MAX);
      q = limit(res_base + res_ofs, 0, RES_MAX);

      // Each accumulator wraps at 32 bits like the hardware registers.
      hp = int'(x - lp_acc - ((bp_acc * q) >>> 8));
      bp = int'(bp_acc + ((hp * f) >>> 8));
      lp = int'(lp_acc + ((bp * f) >>> 8));
      bp_acc = bp;
      lp_acc = lp;

      case (mode_sel)
         MODE_HIGHPASS: y = hp;
         MODE_BANDPASS: y = bp;
         MODE_NOTCH:    y = hp + lp;
         default:       y = lp;
      endcase
      y = limit(y, -32768, 32767);

      // The peak tracker only adapts the gain while the window is open.
      mag = (y < 0) ? -y : y;
      if (win_left != 16'd0) begin
         if (mag > peak_mag) begin
            peak_mag = mag;
            divisor  = (peak_mag == 0) ? 1 : peak_mag;
            gain_q88 = limit((NORM_TARGET * GAIN_UNITY) / divisor, 0, GAIN_MAX);
         end
         win_left = win_left - 16'd1;
      end

      scaled = (y * gain_q88) >>> 8;
      numer  = limit(longint'(boost_num), 2, 6);
      scaled = limit((scaled * numer) / 2, -32768, 32767);

      res.sample_out = scaled[15:0];
      res.gain_now   = gain_q88[10:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cut_base  = 200;
         cut_ofs   = 0;
         res_base  = 100;
         res_ofs   = 0;
         mode_sel  = MODE_LOWPASS;
         win_len   = 16'(WINDOW_RESET);
         boost_num = 3'd2;
         lp_acc    = 0;
         bp_acc    = 0;
         peak_mag  = 1;
         gain_q88  = GAIN_UNITY;
         win_left  = 16'd0;
         errors    = 0;
         expected_samples.delete();
      end else begin
         // Register writes land in the predictor's copy of the settings.
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_CUTOFF_BASE:      cut_base  = pwdata[7:0];
               REG_CUTOFF_OFFSET:    cut_ofs   = $signed(pwdata[8:0]);
               REG_RESONANCE_BASE:   res_base  = pwdata[7:0];
               REG_RESONANCE_OFFSET: res_ofs   = $signed(pwdata[7:0]);
               REG_RESPONSE_MODE:    mode_sel  = pwdata[1:0];
               REG_WINDOW_LENGTH:    win_len   = pwdata[15:0];
               REG_BOOST_NUMERATOR:  boost_num = pwdata[2:0];
               default: ;
            endcase
         end

         // Compare each result transaction with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected result: sample_out %0d gain_now %0d",
                      rsp_data.sample_out, rsp_data.gain_now);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.sample_out !== want.sample_out) begin
                  $error("sample_out expected %0d actual %0d",
                         want.sample_out, rsp_data.sample_out);
                  errors++;
               end
               if (rsp_data.gain_now !== want.gain_now) begin
                  $error("gain_now expected %0d actual %0d",
                         want.gain_now, rsp_data.gain_now);
                  errors++;
               end
            end
         end

         if (req_valid && !req_stall)
            expected_samples.push_back(filter_and_normalize(req_data));
      end
      mismatch_count <= errors;
      pending_count  <= expected_samples.size();
   end

endmodule

// ===== test/tb_svf_filter_peak_normalizer.sv =====
`timescale 1ns / 1ps

module tb_svf_filter_peak_normalizer;

   import svfpn_pkg::*;

   localparam int         REQ_W           = $bits(req_type);
   localparam int         RANDOM_PHASES   = 10;
   localparam int         ITEMS_PER_PHASE = 93;
   localparam int         CALM_PHASE      = 6;
   localparam int         RESONANT_PHASE  = 3;
   localparam int         HOLD_OFF_AT     = 380;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         IDLE_PERCENT    = 29;
   localparam logic [2:0] REG_UNMAPPED    = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_stall = 1'b0;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [4:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;

   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;

   int          mismatches;
   int          outstanding;
   bit          calm       = 1'b0;
   int          items_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   svf_filter_peak_normalizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   svf_peak_norm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatches),
      .pending_count  (outstanding)
   );

   function automatic req_type make_req(logic signed [15:0] smp, logic signed [7:0] mod,
                                        logic st);
      req_type r;
      r.sample_in  = smp;
      r.cutoff_mod = mod;
      r.start_req  = st;
      return r;
   endfunction

   // Offer one sample transaction, with an occasional idle gap before it.
   task automatic send_sample(input req_type item);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(30, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Setup phase, access phase until pready, then an idle bus before the next write.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off that backs up the block.
   initial begin : receiver
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && items_sent >= HOLD_OFF_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          n;
      int          level;
      req_type     item;
      logic [31:0] wl;
      level = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Power-up settings: full-scale inputs, modulation extremes, quiet note.
      send_sample(make_req(16'sh7FFF, 8'sh7F, 1'b1));
      send_sample(make_req(16'sh7FFF, 8'sh00, 1'b0));
      send_sample(make_req(16'sh8000, 8'sh80, 1'b0));
      send_sample(make_req(16'sh8000, 8'sh00, 1'b0));
      send_sample(make_req(16'sh0000, 8'sh7F, 1'b0));
      send_sample(make_req(16'sd1000, 8'sh80, 1'b0));
      send_sample(make_req(16'sd100, 8'sh00, 1'b1));
      send_sample(make_req(-16'sd50, 8'sh00, 1'b0));

      // Lowest cutoff and damping clamps, zero window, boost above range,
      // and a write to an unmapped slot that must leave everything alone.
      settle();
      csr_write(REG_RESPONSE_MODE, 32'(MODE_HIGHPASS));
      csr_write(REG_BOOST_NUMERATOR, 32'd7);
      csr_write(REG_CUTOFF_BASE, 32'd0);
      csr_write(REG_CUTOFF_OFFSET, 32'h100);
      csr_write(REG_RESONANCE_BASE, 32'd0);
      csr_write(REG_RESONANCE_OFFSET, 32'h80);
      csr_write(REG_WINDOW_LENGTH, 32'd0);
      csr_write(REG_UNMAPPED, $urandom);
      send_sample(make_req(16'sd20000, 8'sh80, 1'b1));
      send_sample(make_req(16'sh8000, 8'sh7F, 1'b0));
      send_sample(make_req(16'sh7FFF, 8'sh00, 1'b0));

      // Highest clamps, widest window, boost below range.
      settle();
      csr_write(REG_RESPONSE_MODE, 32'(MODE_BANDPASS));
      csr_write(REG_BOOST_NUMERATOR, 32'd0);
      csr_write(REG_CUTOFF_BASE, 32'd255);
      csr_write(REG_CUTOFF_OFFSET, 32'h0FF);
      csr_write(REG_RESONANCE_BASE, 32'd255);
      csr_write(REG_RESONANCE_OFFSET, 32'h7F);
      csr_write(REG_WINDOW_LENGTH, 32'hFFFF);
      send_sample(make_req(16'sh7FFF, 8'sh7F, 1'b1));
      send_sample(make_req(16'sh8000, 8'sh80, 1'b0));
      send_sample(make_req(16'sd12345, 8'sh00, 1'b0));

      // Notch with the largest boost and a window that closes mid-note.
      settle();
      csr_write(REG_RESPONSE_MODE, 32'(MODE_NOTCH));
      csr_write(REG_BOOST_NUMERATOR, 32'd6);
      csr_write(REG_WINDOW_LENGTH, 32'd3);
      send_sample(make_req(16'sh8000, 8'sh00, 1'b1));
      send_sample(make_req(16'sh7FFF, 8'sh00, 1'b0));
      send_sample(make_req(16'sh8000, 8'sh00, 1'b0));
      send_sample(make_req(16'sh7FFF, 8'sh00, 1'b0));
      send_sample(make_req(16'sh8000, 8'sh00, 1'b0));
      send_sample(make_req(16'sd5, 8'sh00, 1'b1));

      // Random phases: new settings, then notes that begin with a start.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         calm = (phase == CALM_PHASE);
         csr_write(REG_RESPONSE_MODE, 32'(phase[1:0]));
         csr_write(REG_BOOST_NUMERATOR, $urandom_range(7));
         case ($urandom_range(3))
            0: wl = 32'd0;
            1: wl = $urandom_range(150, 1);
            2: wl = WINDOW_RESET;
            default: wl = 32'hFFFF;
         endcase
         csr_write(REG_WINDOW_LENGTH, wl);
         if (phase == RESONANT_PHASE) begin
            // Top cutoff with no damping pushes the accumulators hardest.
            csr_write(REG_CUTOFF_BASE, 32'd255);
            csr_write(REG_CUTOFF_OFFSET, 32'h0FF);
            csr_write(REG_RESONANCE_BASE, 32'd0);
            csr_write(REG_RESONANCE_OFFSET, 32'h80);
         end else begin
            csr_write(REG_CUTOFF_BASE, ($urandom_range(4) == 0) ?
                      ($urandom_range(1) ? 32'd255 : 32'd0) : $urandom_range(255));
            csr_write(REG_CUTOFF_OFFSET, ($urandom_range(4) == 0) ?
                      ($urandom_range(1) ? 32'h0FF : 32'h100) : $urandom_range(511));
            csr_write(REG_RESONANCE_BASE, $urandom_range(255));
            csr_write(REG_RESONANCE_OFFSET, $urandom_range(255));
         end

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            item.start_req = (n == 0) || ($urandom_range(99) < 4);
            if (item.start_req)
               level = $urandom_range(3);
            case (level)
               0: item.sample_in = 16'($urandom);
               1: item.sample_in = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
               2: item.sample_in = 16'($urandom_range(400)) - 16'd200;
               default: item.sample_in = 16'($urandom_range(8000)) - 16'd4000;
            endcase
            if ($urandom_range(9) == 0)
               item.cutoff_mod = $urandom_range(1) ? 8'sh7F : 8'sh80;
            else
               item.cutoff_mod = 8'($urandom);
            // A tenth of the items are pure noise, start flag included.
            if ($urandom_range(99) < 10)
               item = REQ_W'($urandom);
            send_sample(item);
         end
      end
      calm = 1'b0;

      settle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("svf_filter_peak_normalizer regression: pass");
      else
         $display("svf_filter_peak_normalizer regression: fail");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #6_000_000;
      $display("svf_filter_peak_normalizer regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/svfpn_pkg.sv
hdl/svfpn_csr.sv
hdl/svfpn_mul.sv
hdl/svfpn_div.sv
hdl/svf_filter_peak_normalizer.sv
test/svf_peak_norm_checker.sv
test/tb_svf_filter_peak_normalizer.sv
